// ===== sv/tcwc_pkg.sv =====
// tcwc_pkg: shared types, codes and field widths for the trace capture
// window controller. No dependencies; used by the core, the top level and
// the checker.
package tcwc_pkg;

  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int STATE_W   = 3;
  localparam int INDEX_W   = 16;
  localparam int FRAMES_W  = 16;
  localparam int TICKS_W   = 32;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // output word layout, lowest bit up
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_FIN_LSB    = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_STATE_LSB  = OUT_FIN_LSB + 1;
  localparam int OUT_INDEX_LSB  = OUT_STATE_LSB + STATE_W;

  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_TICKS  = 1'd1;

  localparam logic [FRAMES_W-1:0] CAPTURE_FRAMES_RST = 16'd1;
  localparam logic [TICKS_W-1:0]  CAPTURE_TICKS_RST  = 32'd1000;

  typedef enum logic [STATE_W-1:0] {
    ST_UNKNOWN   = 3'd0,
    ST_IDLE      = 3'd1,
    ST_TRIGGERED = 3'd2,
    ST_TRACING   = 3'd3,
    ST_FINISHED  = 3'd4
  } trc_state_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NEW_FRAME     = 3'd0,
    CMD_TICK          = 3'd1,
    CMD_TRIGGER       = 3'd2,
    CMD_POLL          = 3'd3,
    CMD_COLLECT       = 3'd4,
    CMD_RESET_TRACE   = 3'd5,
    CMD_RESET_SESSION = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK    = 2'd0,
    RES_WRONG = 2'd1,
    RES_HOOK  = 2'd2
  } status_t;

  typedef struct packed {
    logic [INDEX_W-1:0] capture_index;
    logic [STATE_W-1:0] state_now;
    logic               finished;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ===== sv/tcwc_core.sv =====
// tcwc_core: capture state, counters and the per-event transition logic.
// One event is applied per cycle on fire. Depends on tcwc_pkg.
module tcwc_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [tcwc_pkg::CMD_W-1:0]    cmd,
  input  logic                          hook_ok,
  input  logic [tcwc_pkg::FRAMES_W-1:0] capture_frames,
  input  logic [tcwc_pkg::TICKS_W-1:0]  capture_ticks,
  output tcwc_pkg::result_t             res
);
  import tcwc_pkg::*;

  trc_state_t         state_r, state_nxt;
  logic               pend_frame_r, pend_frame_nxt;
  logic               act_frame_r, act_frame_nxt;
  logic [COUNT_W-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [COUNT_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [COUNT_W-1:0] start_frame_r, start_frame_nxt;
  logic [COUNT_W-1:0] start_tick_r, start_tick_nxt;
  logic [COUNT_W-1:0] limit_r, limit_nxt;
  logic [INDEX_W-1:0] session_r, session_nxt;
  logic [INDEX_W-1:0] act_index_r, act_index_nxt;

  status_t            status;
  logic               fin;
  logic [INDEX_W-1:0] idx;
  logic               do_adv;
  logic [COUNT_W-1:0] span;

  always_comb begin
    state_nxt       = state_r;
    pend_frame_nxt  = pend_frame_r;
    act_frame_nxt   = act_frame_r;
    frame_cnt_nxt   = frame_cnt_r;
    tick_cnt_nxt    = tick_cnt_r;
    start_frame_nxt = start_frame_r;
    start_tick_nxt  = start_tick_r;
    limit_nxt       = limit_r;
    session_nxt     = session_r;
    act_index_nxt   = act_index_r;
    status          = RES_OK;
    fin             = 1'b0;
    idx             = '0;
    do_adv          = 1'b0;

    case (cmd_t'(cmd))
      CMD_NEW_FRAME: begin
        frame_cnt_nxt  = frame_cnt_r + COUNT_W'(1);
        pend_frame_nxt = 1'b1;
        do_adv         = 1'b1;
      end
      CMD_TICK: begin
        tick_cnt_nxt = tick_cnt_r + COUNT_W'(1);
      end
      CMD_TRIGGER: begin
        if (state_r != ST_IDLE) begin
          status = RES_WRONG;
        end else begin
          state_nxt = ST_TRIGGERED;
          // duration mode starts straight away
          do_adv    = !pend_frame_r;
        end
      end
      CMD_POLL: begin
        if (state_r inside {ST_IDLE, ST_UNKNOWN}) begin
          status = RES_WRONG;
        end else if (state_r == ST_TRIGGERED) begin
          fin = 1'b0;
        end else if (act_frame_r || state_r == ST_FINISHED) begin
          fin = (state_r == ST_FINISHED);
        end else begin
          // duration capture still tracing: check its end, answer 0
          do_adv = 1'b1;
        end
      end
      CMD_COLLECT: begin
        if (state_r != ST_FINISHED) begin
          status = RES_WRONG;
        end else if (!hook_ok) begin
          state_nxt = ST_UNKNOWN;
          status    = RES_HOOK;
        end else begin
          idx         = act_index_r;
          session_nxt = session_r + INDEX_W'(1);
          state_nxt   = ST_IDLE;
        end
      end
      CMD_RESET_TRACE: begin
        state_nxt = ST_IDLE;
      end
      CMD_RESET_SESSION: begin
        state_nxt      = ST_IDLE;
        session_nxt    = '0;
        frame_cnt_nxt  = '0;
        pend_frame_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    span = act_frame_r ? (frame_cnt_nxt - start_frame_r) : (tick_cnt_r - start_tick_r);

    // start or end check of the capture, on the already-updated counters
    if (do_adv) begin
      if (state_nxt == ST_TRIGGERED) begin
        if (!hook_ok) begin
          state_nxt = ST_UNKNOWN;
          status    = RES_HOOK;
        end else begin
          act_frame_nxt   = pend_frame_nxt;
          limit_nxt       = pend_frame_nxt ? {{(COUNT_W-FRAMES_W){1'b0}}, capture_frames}
                                           : capture_ticks;
          act_index_nxt   = session_r;
          start_frame_nxt = frame_cnt_nxt;
          start_tick_nxt  = tick_cnt_r;
          state_nxt       = ST_TRACING;
        end
      end else if (state_nxt == ST_TRACING && span >= limit_r) begin
        if (!hook_ok) begin
          state_nxt = ST_UNKNOWN;
          status    = RES_HOOK;
        end else begin
          state_nxt = ST_FINISHED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pend_frame_r  <= 1'b0;
      act_frame_r   <= 1'b0;
      frame_cnt_r   <= '0;
      tick_cnt_r    <= '0;
      start_frame_r <= '0;
      start_tick_r  <= '0;
      limit_r       <= '0;
      session_r     <= '0;
      act_index_r   <= '0;
    end else if (fire) begin
      state_r       <= state_nxt;
      pend_frame_r  <= pend_frame_nxt;
      act_frame_r   <= act_frame_nxt;
      frame_cnt_r   <= frame_cnt_nxt;
      tick_cnt_r    <= tick_cnt_nxt;
      start_frame_r <= start_frame_nxt;
      start_tick_r  <= start_tick_nxt;
      limit_r       <= limit_nxt;
      session_r     <= session_nxt;
      act_index_r   <= act_index_nxt;
    end
  end

  assign res.status        = status;
  assign res.finished      = fin;
  assign res.state_now     = state_nxt;
  assign res.capture_index = idx;

endmodule

// ===== sv/trace_capture_window_controller_top.sv =====
// trace_capture_window_controller_top: stream ports, input and output word
// registers and the configuration registers around tcwc_core.
// Depends on tcwc_pkg and tcwc_core.
//
//   port group  dir  fields (lowest bit up)
//   in_*        in   tdata: cmd[2:0], hook_ok[3], zeros[7:4]
//   out_*       out  tdata: status[1:0], finished[2], state_now[5:3],
//                    capture_index[21:6], zeros[23:22]
//   cfg_*       in   index 0 capture_frames, 1 capture_ticks
//
// One event per cycle sustained while the output is accepted; a result goes from
// the input register through the core logic into the output register, and is
// held there until out_tready takes it.
// Every event updates the state in the cycle it leaves the input register.
// rst_n is synchronous: idle state, counters cleared, registers to defaults.
// A stalled output holds its word; the input register still takes one more.
module trace_capture_window_controller_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcwc_pkg::IN_TDATA_W-1:0] in_tdata,    // cmd, hook_ok
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcwc_pkg::OUT_TDATA_W-1:0] out_tdata,  // status, finished, state_now, capture_index
  input  logic                            cfg_we,
  input  logic [tcwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcwc_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import tcwc_pkg::*;

  logic                in_valid_r;
  logic [CMD_W-1:0]    in_cmd_r;
  logic                in_hook_r;
  logic                out_valid_r;
  result_t             out_res_r;
  logic [FRAMES_W-1:0] cap_frames_r;
  logic [TICKS_W-1:0]  cap_ticks_r;
  logic                advance;
  logic                fire;
  result_t             res;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_frames_r <= CAPTURE_FRAMES_RST;
      cap_ticks_r  <= CAPTURE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPTURE_FRAMES: cap_frames_r <= cfg_wdata[FRAMES_W-1:0];
        REG_CAPTURE_TICKS:  cap_ticks_r  <= cfg_wdata[TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= in_tdata[CMD_W-1:0];
      in_hook_r <= in_tdata[CMD_W];
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  tcwc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .cmd            (in_cmd_r),
    .hook_ok        (in_hook_r),
    .capture_frames (cap_frames_r),
    .capture_ticks  (cap_ticks_r),
    .res            (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, out_res_r};

endmodule

// ===== sv/tcwc_checker.sv =====
// tcwc_checker: port-level checks on the result stream of the controller,
// attached by bind below. Depends on tcwc_pkg.
module tcwc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tcwc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcwc_pkg::*;

  logic [STATUS_W-1:0] o_status;
  logic                o_fin;
  logic [STATE_W-1:0]  o_state;
  logic [INDEX_W-1:0]  o_index;

  assign o_status = out_tdata[OUT_STATUS_LSB +: STATUS_W];
  assign o_fin    = out_tdata[OUT_FIN_LSB];
  assign o_state  = out_tdata[OUT_STATE_LSB +: STATE_W];
  assign o_index  = out_tdata[OUT_INDEX_LSB +: INDEX_W];

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a failed hook always leaves the capture in unknown
  a_hook_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_status == RES_HOOK |-> o_state == ST_UNKNOWN)
    else $error("hook failure without unknown state");

  // poll says finished only for a finished capture
  a_fin_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_fin |-> o_state == ST_FINISHED && o_status == RES_OK)
    else $error("finished flag outside finished state");

  // an index comes only with a successful collect, which returns to idle
  a_index_collect: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_index != '0 |-> o_status == RES_OK && o_state == ST_IDLE)
    else $error("capture index outside successful collect");

endmodule

bind trace_capture_window_controller_top tcwc_checker u_tcwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/testbench.sv =====
// testbench: self-checking bench for trace_capture_window_controller_top.
// Holds its own capture-state predictor, a bursty word driver and a stalling
// reply monitor. Depends on tcwc_pkg and the RTL of the top level only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcwc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic             hook;
    logic [CMD_W-1:0] cmd;
  } event_word_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_MASK, RX_LONG} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DAT_W-1:0]   cfg_wdata = '0;

  trace_capture_window_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the controller
  trc_state_t         trc_state;
  logic               pend_frame_mode;
  logic               act_frame_mode;
  logic [COUNT_W-1:0] frame_cnt;
  logic [COUNT_W-1:0] tick_cnt;
  logic [COUNT_W-1:0] frame_mark;
  logic [COUNT_W-1:0] tick_mark;
  logic [COUNT_W-1:0] act_limit;
  logic [INDEX_W-1:0] session_cnt;
  logic [INDEX_W-1:0] act_index;
  logic [FRAMES_W-1:0] frames_len;
  logic [TICKS_W-1:0]  ticks_len;

  event_word_t event_backlog[$];
  result_t     awaited_replies[$];
  int          items_queued = 0;
  int          bad_replies = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  rx_mode_t    rx_mode = RX_STEADY;
  int          rx_left = 0;
  logic [7:0]  rx_mask = '1;
  logic [4:0]  rx_phase = '0;
  int          quiet_cycles = 0;

  // start the capture from triggered, or check the end of a running one
  function automatic status_t advance_capture(input logic hook);
    logic [COUNT_W-1:0] span;
    advance_capture = RES_OK;
    if (trc_state == ST_TRIGGERED) begin
      if (!hook) begin
        trc_state = ST_UNKNOWN;
        advance_capture = RES_HOOK;
      end else begin
        act_frame_mode = pend_frame_mode;
        act_limit = pend_frame_mode ? {16'd0, frames_len} : ticks_len;
        act_index = session_cnt;
        frame_mark = frame_cnt;
        tick_mark = tick_cnt;
        trc_state = ST_TRACING;
      end
    end else if (trc_state == ST_TRACING) begin
      span = act_frame_mode ? frame_cnt - frame_mark : tick_cnt - tick_mark;
      if (span >= act_limit) begin
        if (!hook) begin
          trc_state = ST_UNKNOWN;
          advance_capture = RES_HOOK;
        end else begin
          trc_state = ST_FINISHED;
        end
      end
    end
  endfunction

  function automatic result_t step_capture_event(input logic [CMD_W-1:0] cmd, input logic hook);
    result_t r;
    r = '0;
    case (cmd)
      CMD_NEW_FRAME: begin
        frame_cnt = frame_cnt + 32'd1;
        pend_frame_mode = 1'b1;
        r.status = advance_capture(hook);
      end
      CMD_TICK: tick_cnt = tick_cnt + 32'd1;
      CMD_TRIGGER: begin
        if (trc_state != ST_IDLE) begin
          r.status = RES_WRONG;
        end else begin
          trc_state = ST_TRIGGERED;
          if (!pend_frame_mode) r.status = advance_capture(hook);
        end
      end
      CMD_POLL: begin
        if (trc_state == ST_IDLE || trc_state == ST_UNKNOWN) r.status = RES_WRONG;
        else if (trc_state == ST_TRIGGERED) r.finished = 1'b0;
        else if (act_frame_mode) r.finished = (trc_state == ST_FINISHED);
        else if (trc_state == ST_FINISHED) r.finished = 1'b1;
        else r.status = advance_capture(hook);
      end
      CMD_COLLECT: begin
        if (trc_state != ST_FINISHED) begin
          r.status = RES_WRONG;
        end else if (!hook) begin
          trc_state = ST_UNKNOWN;
          r.status = RES_HOOK;
        end else begin
          r.capture_index = act_index;
          session_cnt = session_cnt + 16'd1;
          trc_state = ST_IDLE;
        end
      end
      CMD_RESET_TRACE: trc_state = ST_IDLE;
      CMD_RESET_SESSION: begin
        trc_state = ST_IDLE;
        session_cnt = '0;
        frame_cnt = '0;
        pend_frame_mode = 1'b0;
      end
      default: ;
    endcase
    r.state_now = trc_state;
    return r;
  endfunction

  // word driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    event_word_t next_word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left = 0;
      gap_left = 0;
      trc_state = ST_IDLE;
      pend_frame_mode = 1'b0;
      act_frame_mode = 1'b0;
      frame_cnt = '0;
      tick_cnt = '0;
      frame_mark = '0;
      tick_mark = '0;
      act_limit = '0;
      session_cnt = '0;
      act_index = '0;
      frames_len = CAPTURE_FRAMES_RST;
      ticks_len = CAPTURE_TICKS_RST;
    end else begin
      if (in_tvalid && in_tready)
        awaited_replies.push_back(step_capture_event(in_tdata[2:0], in_tdata[3]));
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0 || event_backlog.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          next_word = event_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'd0, next_word};
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // reply monitor; ready follows a stall pattern that changes now and then
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[OUT_STATUS_LSB +: STATUS_W];
        got.finished = out_tdata[OUT_FIN_LSB];
        got.state_now = out_tdata[OUT_STATE_LSB +: STATE_W];
        got.capture_index = out_tdata[OUT_INDEX_LSB +: INDEX_W];
        if (awaited_replies.size() == 0) begin
          bad_replies++;
          if (bad_replies <= 10)
            $display("%0t: reply with none awaited: %h", $realtime, out_tdata);
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status || got.finished !== want.finished ||
              got.state_now !== want.state_now || got.capture_index !== want.capture_index) begin
            bad_replies++;
            if (bad_replies <= 10)
              $display("%0t: mismatch status %0d/%0d finished %0d/%0d state %0d/%0d index %0d/%0d",
                       $realtime, want.status, got.status, want.finished, got.finished,
                       want.state_now, got.state_now, want.capture_index, got.capture_index);
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
        rx_mask = 8'($urandom) | 8'd1;
      end
      rx_left--;
      rx_phase = rx_phase + 5'd1;
      case (rx_mode)
        RX_STEADY: out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_MASK:   out_tready <= rx_mask[rx_phase[2:0]];
        default:   out_tready <= (rx_phase >= 5'd18);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[trace_capture_window_controller_top] ERROR");
      $finish;
    end
  end

  task automatic queue_event(input logic [CMD_W-1:0] cmd, input logic hook);
    event_word_t w;
    w.cmd = cmd;
    w.hook = hook;
    event_backlog.push_back(w);
    if (cmd != CMD_UNUSED) items_queued++;
  endtask

  function automatic logic mostly_ok();
    return ($urandom_range(0, 15) != 0);
  endfunction

  task automatic wait_quiet();
    while (event_backlog.size() != 0 || in_tvalid || awaited_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == REG_CAPTURE_FRAMES) frames_len = value[FRAMES_W-1:0];
    else ticks_len = value;
  endtask

  // one capture: clear, arm, run a random number of steps toward or past its length, poll and collect
  task automatic add_capture_run();
    logic frame_mode;
    int   limit;
    int   steps;
    frame_mode = 1'($urandom_range(0, 1));
    if (frame_mode) begin
      queue_event(CMD_RESET_TRACE, 1'($urandom_range(0, 1)));
      queue_event(CMD_NEW_FRAME, 1'b1);
      limit = frames_len;
    end else begin
      queue_event(CMD_RESET_SESSION, 1'($urandom_range(0, 1)));
      limit = (ticks_len > 32'd64) ? 64 : int'(ticks_len);
    end
    queue_event(CMD_TRIGGER, mostly_ok());
    steps = (limit > 10) ? $urandom_range(0, 10) : limit + $urandom_range(0, 2);
    if (frame_mode) queue_event(CMD_NEW_FRAME, mostly_ok());
    for (int i = 0; i < steps; i++) begin
      queue_event(frame_mode ? CMD_NEW_FRAME : CMD_TICK, mostly_ok());
      if ($urandom_range(0, 3) == 0)
        queue_event($urandom_range(0, 1) ? CMD_POLL : CMD_TICK, mostly_ok());
    end
    queue_event(CMD_POLL, mostly_ok());
    queue_event(CMD_POLL, mostly_ok());
    queue_event(CMD_COLLECT, mostly_ok());
    if ($urandom_range(0, 5) == 0) queue_event(CMD_COLLECT, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input logic [31:0] frames_val, input logic [31:0] ticks_val,
                           input int count);
    int goal;
    wait_quiet();
    write_reg(REG_CAPTURE_FRAMES, frames_val);
    write_reg(REG_CAPTURE_TICKS, ticks_val);
    goal = items_queued + count;
    while (items_queued < goal) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3))
          queue_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
        add_capture_run();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset lengths (1 frame, 1000 ticks)
    queue_event(CMD_POLL, 1'b1);            // poll in idle
    queue_event(CMD_COLLECT, 1'b1);         // collect in idle
    queue_event(CMD_UNUSED, 1'b0);          // spare command code, ignored
    queue_event(CMD_TICK, 1'b0);
    queue_event(CMD_TRIGGER, 1'b1);         // duration mode starts at once
    queue_event(CMD_TRIGGER, 1'b1);
    queue_event(CMD_POLL, 1'b1);
    queue_event(CMD_COLLECT, 1'b1);         // collect while tracing
    queue_event(CMD_RESET_TRACE, 1'b0);
    queue_event(CMD_TRIGGER, 1'b0);         // start hook fails
    queue_event(CMD_TICK, 1'b1);            // counting goes on in unknown
    queue_event(CMD_NEW_FRAME, 1'b1);
    queue_event(CMD_POLL, 1'b0);
    queue_event(CMD_TRIGGER, 1'b1);
    queue_event(CMD_RESET_TRACE, 1'b1);
    queue_event(CMD_TRIGGER, 1'b1);         // frame mode waits for a frame
    queue_event(CMD_POLL, 1'b1);
    queue_event(CMD_NEW_FRAME, 1'b1);
    queue_event(CMD_NEW_FRAME, 1'b0);       // end hook fails
    queue_event(CMD_RESET_TRACE, 1'b0);
    queue_event(CMD_TRIGGER, 1'b1);
    queue_event(CMD_NEW_FRAME, 1'b1);
    queue_event(CMD_NEW_FRAME, 1'b1);
    queue_event(CMD_POLL, 1'b1);
    queue_event(CMD_COLLECT, 1'b0);         // collect hook fails
    queue_event(CMD_RESET_SESSION, 1'b0);

    run_phase(32'd0, 32'd0, 175);
    run_phase(32'd2, 32'd3, 175);
    run_phase(32'h0000_FFFF, 32'hFFFF_FFFF, 175);
    run_phase({16'($urandom), 16'($urandom_range(0, 4))}, 32'($urandom_range(0, 6)), 175);
    run_phase(32'($urandom), 32'($urandom), 100);

    wait_quiet();
    repeat (8) @(posedge clk);
    if (bad_replies == 0)
      $display("[trace_capture_window_controller_top] OK");
    else
      $display("[trace_capture_window_controller_top] ERROR");
    $finish;
  end

endmodule
